### src/clamped_fixed_width_histogram_assert.svh
// Assertion macros shared by the histogram RTL.
// Needs nothing else; the including module supplies clock and reset names.
`ifndef CLAMPED_FIXED_WIDTH_HISTOGRAM_ASSERT_SVH
`define CLAMPED_FIXED_WIDTH_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CFWH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram assertion failed");

// Next-cycle implication, disabled during reset.
`define CFWH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram assertion failed");

`endif

### src/cfwh_pkg.sv
// Package for the clamped fixed-width histogram: widths, defaults and codes.
// Used by the top level; depends on nothing.
package cfwh_pkg;

  localparam int MAX_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int STEP_W     = 31;
  localparam int NBINS_W    = 11;
  localparam int BIN_W      = 10;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WIDE_IDX_W = 17;
  localparam int CNT_EXT_W  = 64;
  localparam int DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS  = 2'd2;

  localparam logic [SAMPLE_W-1:0] MIN_VAL_RST   = 32'd0;
  localparam logic [STEP_W-1:0]   BIN_WIDTH_RST = 31'd65536;
  localparam logic [NBINS_W-1:0]  NUM_BINS_RST  = 11'd1024;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

endpackage

### src/cfwh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the histogram count store.
module cfwh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/clamped_fixed_width_histogram.sv
// Top level of the clamped fixed-width histogram: sequencer, serial divider, count store.
// Depends on cfwh_pkg, cfwh_ram and clamped_fixed_width_histogram_assert.svh.
//
// Use: an item is taken at a clock edge with start high and busy low. An add item
// (in_action 0) bins in_sample_value as floor((sample - min_val) / bin width),
// clamped into the bins in use, and bumps that bin's saturating counter. A read
// item (in_action 1) returns the count of in_read_bin without changing it.
// Each item gives one result, shown on out_bin_index and out_bin_count for one
// cycle while out_valid is high; the receiver cannot stall it.
// An add item passes from acceptance through the restoring divider over the 32-bit
// dividend, one quotient bit a cycle, then S_LOC, which addresses the count store,
// then S_WAIT, which reads the count and writes it back, and the output register.
// A read item skips the divider. busy falls in the cycle the result is shown, so the
// next item may be accepted at the edge that takes the result.
// After reset the count store is cleared, one entry a cycle,
// with busy high; configuration writes are taken at any time through cfg_we,
// cfg_index and cfg_wdata, but are meant only while the block is idle.
module clamped_fixed_width_histogram #(
  parameter int MAX_BINS    = cfwh_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = cfwh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_action,
  input  logic signed [cfwh_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [cfwh_pkg::BIN_W-1:0]            in_read_bin,
  output logic                                  out_valid,
  output logic [cfwh_pkg::BIN_W-1:0]            out_bin_index,
  output logic [cfwh_pkg::OUT_CNT_W-1:0]        out_bin_count,
  input  logic                                  cfg_we,
  input  logic [cfwh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cfwh_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import cfwh_pkg::*;

  `include "clamped_fixed_width_histogram_assert.svh"

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [WIDE_IDX_W-1:0] MAX_BINS_W = WIDE_IDX_W'(MAX_BINS);
  localparam logic [IDX_W-1:0]      LAST_ADDR  = IDX_W'(MAX_BINS - 1);
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST   = DIV_CNT_W'(SAMPLE_W - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_LOC,
    S_WAIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       clr_r, clr_nxt;
  logic [DIV_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [SAMPLE_W-1:0]    min_val_r;
  logic [STEP_W-1:0]      step_r;
  logic [NBINS_W-1:0]     nbins_r;

  logic                   act_r;
  logic [BIN_W-1:0]       rb_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   oor_r;
  logic [SAMPLE_W-1:0]    quo_r;
  logic [STEP_W-1:0]      rem_r;
  logic [BIN_W-1:0]       out_bin_index_r;
  logic [OUT_CNT_W-1:0]   out_bin_count_r;

  logic [STEP_W-1:0]      step_eff;
  logic [WIDE_IDX_W-1:0]  nb_wide;
  logic [WIDE_IDX_W-1:0]  nb_eff;
  logic [WIDE_IDX_W-1:0]  last_wide;
  logic [SAMPLE_W:0]      diff;
  logic [SAMPLE_W-1:0]    dividend;
  logic [SAMPLE_W-1:0]    trial;
  logic [SAMPLE_W-1:0]    step_ext;
  logic [SAMPLE_W-1:0]    trial_sub;
  logic                   ge;
  logic [IDX_W-1:0]       clamp_idx;
  logic [WIDE_IDX_W-1:0]  rb_wide;
  logic                   rb_oor;
  logic [WIDE_IDX_W-1:0]  idx_wide;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] result_cnt;
  logic [CNT_EXT_W-1:0]   cnt_ext;

  cfwh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_BINS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    step_eff  = (step_r == '0) ? STEP_W'(1) : step_r;
    nb_wide   = WIDE_IDX_W'(nbins_r);
    if (nb_wide == '0) begin
      nb_eff = WIDE_IDX_W'(1);
    end else if (nb_wide > MAX_BINS_W) begin
      nb_eff = MAX_BINS_W;
    end else begin
      nb_eff = nb_wide;
    end
    last_wide = nb_eff - WIDE_IDX_W'(1);

    diff      = {in_sample_value[SAMPLE_W-1], in_sample_value}
              - {min_val_r[SAMPLE_W-1], min_val_r};
    dividend  = diff[SAMPLE_W] ? '0 : diff[SAMPLE_W-1:0];

    trial     = {rem_r, quo_r[SAMPLE_W-1]};
    step_ext  = {1'b0, step_eff};
    ge        = (trial >= step_ext);
    trial_sub = trial - step_ext;

    clamp_idx = (quo_r > SAMPLE_W'(last_wide)) ? last_wide[IDX_W-1:0]
                                               : quo_r[IDX_W-1:0];

    rb_wide   = WIDE_IDX_W'(in_read_bin);
    rb_oor    = (rb_wide >= MAX_BINS_W);
    idx_wide  = WIDE_IDX_W'(idx_r);

    cnt_inc    = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
    if (act_r == ACT_READ) begin
      result_cnt = oor_r ? '0 : ram_rdata;
    end else begin
      result_cnt = cnt_inc;
    end
    cnt_ext = CNT_EXT_W'(result_cnt);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    clr_nxt       = clr_r;
    bit_cnt_nxt   = bit_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = cnt_inc;
    ram_raddr     = idx_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          bit_cnt_nxt = DIV_LAST;
          state_nxt   = (in_action == ACT_READ) ? S_LOC : S_DIV;
        end
      end
      S_DIV: begin
        bit_cnt_nxt = bit_cnt_r - DIV_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = S_LOC;
        end
      end
      S_LOC: begin
        ram_raddr = (act_r == ACT_READ) ? idx_r : clamp_idx;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        ram_we        = (act_r == ACT_ADD);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      out_valid_r     <= 1'b0;
      out_bin_index_r <= '0;
      out_bin_count_r <= '0;
      clr_r           <= '0;
      bit_cnt_r       <= '0;
      min_val_r       <= MIN_VAL_RST;
      step_r          <= BIN_WIDTH_RST;
      nbins_r         <= NUM_BINS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      if (state_r == S_WAIT) begin
        out_bin_index_r <= (act_r == ACT_READ) ? rb_r : idx_wide[BIN_W-1:0];
        out_bin_count_r <= cnt_ext[OUT_CNT_W-1:0];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_VAL:   min_val_r <= cfg_wdata;
          CFG_BIN_WIDTH: step_r    <= cfg_wdata[STEP_W-1:0];
          CFG_NUM_BINS:  nbins_r   <= cfg_wdata[NBINS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_r <= in_action;
          rb_r  <= in_read_bin;
          idx_r <= rb_wide[IDX_W-1:0];
          oor_r <= rb_oor;
          quo_r <= dividend;
          rem_r <= '0;
        end
      end
      S_DIV: begin
        quo_r <= {quo_r[SAMPLE_W-2:0], ge};
        rem_r <= ge ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
      end
      S_LOC: begin
        if (act_r == ACT_ADD) begin
          idx_r <= clamp_idx;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_bin_index = out_bin_index_r;
  assign out_bin_count = out_bin_count_r;

  `CFWH_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid_r, !busy)
  `CFWH_ASSERT_NEXT(a_accept_makes_busy, clk, rst_n, start && !busy, busy)
  `CFWH_ASSERT_SAME(a_rem_below_step, clk, rst_n, state_r == S_DIV, rem_r < step_eff)
  `CFWH_ASSERT_NEXT(a_wait_gives_result, clk, rst_n, state_r == S_WAIT, out_valid_r)

endmodule
